@@ rtl/pdts_pkg.sv @@
package pdts_pkg;

	localparam int MAX_PASSES_D    = 16;
	localparam int MAX_RESOURCES_D = 16;
	localparam int IDX_W           = 4;
	localparam int TOTAL_W         = 5;
	localparam int EXT_W           = 16;
	localparam int CFG_IDX_W       = 2;

	typedef enum logic [2:0] {
		MODE_READ    = 3'd0,
		MODE_WRITE   = 3'd1,
		MODE_DEP     = 3'd2,
		MODE_COMPILE = 3'd3,
		MODE_CLEAR   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ORDER  = 2'd0,
		KIND_LIFE   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MULTI_WR = 2'd1,
		ST_NO_WR    = 2'd2,
		ST_CYCLE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_PASS_TOTAL = 2'd0,
		REG_RES_TOTAL  = 2'd1,
		REG_EXTERNAL   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_W,
		S_CHK_RD,
		S_PRED,
		S_SORT,
		S_EMIT_ORD,
		S_EMIT_LIFE,
		S_EMIT_STAT
	} state_t;

	typedef struct packed {
		logic ld_rd;
		logic ld_wr;
		logic ld_dep;
		logic clr;
		logic pred_init;
		logic pred_add;
		logic sort_init;
		logic sort_step;
	} cell_ctrl_t;

endpackage

@@ rtl/pdts_cell.sv @@
module pdts_cell #(
	parameter int MAX_PASSES    = pdts_pkg::MAX_PASSES_D,
	parameter int MAX_RESOURCES = pdts_pkg::MAX_RESOURCES_D,
	parameter int CELL_ID       = 0,
	localparam int PIW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pdts_pkg::cell_ctrl_t         ctrl,
	input  logic [pdts_pkg::IDX_W-1:0]   load_pass,
	input  logic [MAX_RESOURCES-1:0]     load_r,
	input  logic [MAX_PASSES-1:0]        load_p,
	input  logic [MAX_PASSES-1:0]        pmask,
	input  logic [MAX_RESOURCES-1:0]     bcast_r,
	input  logic [MAX_PASSES-1:0]        bcast_w,
	input  logic [MAX_PASSES-1:0]        emitted,
	input  logic                         in_range,
	input  logic                         found_in,
	input  logic [PIW-1:0]               cur_pos,
	input  logic [MAX_RESOURCES-1:0]     lt_r,
	input  logic                         lt_w,
	output logic [MAX_RESOURCES-1:0]     rd_row,
	output logic [MAX_RESOURCES-1:0]     wr_row,
	output logic                         done,
	output logic                         found_out,
	output logic                         pick,
	output logic                         touch,
	output logic [PIW-1:0]               pos
);

	localparam logic [MAX_PASSES-1:0] SELF = MAX_PASSES'(1) << CELL_ID;

	logic [MAX_RESOURCES-1:0] rd_q, wr_q;
	logic [MAX_PASSES-1:0]    dep_q, pred_q;
	logic                     done_q;
	logic [PIW-1:0]           pos_q;
	logic                     sel, ready;

	assign sel       = (int'(load_pass) == CELL_ID);
	assign ready     = in_range && !done_q && ((pred_q & ~emitted & ~SELF) == '0);
	assign pick      = ready && !found_in;
	assign found_out = found_in || ready;
	assign touch     = in_range && (((rd_q & lt_r) != '0) || lt_w);
	assign rd_row    = rd_q;
	assign wr_row    = wr_q;
	assign done      = done_q;
	assign pos       = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			wr_q   <= '0;
			dep_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				rd_q  <= '0;
				wr_q  <= '0;
				dep_q <= '0;
			end else if (sel) begin
				if (ctrl.ld_rd) rd_q <= rd_q | load_r;
				if (ctrl.ld_wr) wr_q <= wr_q | load_r;
				if (ctrl.ld_dep) dep_q <= dep_q | load_p;
			end
			if (ctrl.sort_init) begin
				done_q <= 1'b0;
			end else if (ctrl.sort_step && pick) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pred_init) begin
			pred_q <= dep_q & pmask;
		end else if (ctrl.pred_add && ((rd_q & bcast_r) != '0)) begin
			pred_q <= pred_q | bcast_w;
		end
		if (ctrl.sort_step && pick) begin
			pos_q <= cur_pos;
		end
	end

endmodule

@@ rtl/pass_dependency_topo_scheduler.sv @@
// Load items (read, write, dependency, clear) are accepted back to back while no compile runs.
// A compile keeps the item channel stalled until its status item is loaded, also through output
// stalls: it runs the writer scan, the missing-writer check, edge building and the sort, then it
// emits the order, the lifetimes and the status item. A multiple-writer conflict, a failed check
// or a cycle ends the compile early with only the status item.
// Reset (arst_n low, asynchronous) clears the config registers, matrices, state, counter and out_valid.
module pass_dependency_topo_scheduler #(
	parameter int MAX_PASSES    = pdts_pkg::MAX_PASSES_D,
	parameter int MAX_RESOURCES = pdts_pkg::MAX_RESOURCES_D
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdts_pkg::EXT_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     mode,
	input  logic [pdts_pkg::IDX_W-1:0]     pass_index,
	input  logic [pdts_pkg::IDX_W-1:0]     other_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     kind,
	output logic [pdts_pkg::IDX_W-1:0]     index,
	output logic [pdts_pkg::IDX_W-1:0]     first_pos,
	output logic [pdts_pkg::IDX_W-1:0]     last_pos,
	output logic                           used,
	output logic [1:0]                     status,
	output logic                           final_res
);

	localparam int MP   = MAX_PASSES;
	localparam int MR   = MAX_RESOURCES;
	localparam int PIW  = (MP > 1) ? $clog2(MP) : 1;
	localparam int RIW  = (MR > 1) ? $clog2(MR) : 1;
	localparam int MAXN = (MP > MR) ? MP : MR;
	localparam int CW   = $clog2(MAXN + 1);
	localparam int IW   = pdts_pkg::IDX_W;

	// Configuration registers.
	logic [pdts_pkg::TOTAL_W-1:0] pass_total_q, res_total_q;
	logic [pdts_pkg::EXT_W-1:0]   ext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_total_q <= '0;
			res_total_q  <= '0;
			ext_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pdts_pkg::REG_PASS_TOTAL: pass_total_q <= cfg_data[pdts_pkg::TOTAL_W-1:0];
				pdts_pkg::REG_RES_TOTAL:  res_total_q  <= cfg_data[pdts_pkg::TOTAL_W-1:0];
				pdts_pkg::REG_EXTERNAL:   ext_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective totals clamp to the storage size; masks select the live rows and columns.
	logic [CW-1:0]  np, nr;
	logic [MP-1:0]  pmask;
	logic [MR-1:0]  rmask, ext_vec;

	assign np = (int'(pass_total_q) > MP) ? CW'(MP) : CW'(pass_total_q);
	assign nr = (int'(res_total_q) > MR) ? CW'(MR) : CW'(res_total_q);

	always_comb begin
		for (int j = 0; j < MP; j++) pmask[j] = (j < int'(np));
		for (int j = 0; j < MR; j++) begin
			rmask[j]   = (j < int'(nr));
			ext_vec[j] = (j < pdts_pkg::EXT_W) ? ext_q[j % pdts_pkg::EXT_W] : 1'b0;
		end
	end

	// Sequencer state.
	pdts_pkg::state_t  state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [MR-1:0]     hw_q, hw_d, hr_q, hr_d;
	logic [PIW-1:0]    writer_q [MR];
	logic [PIW-1:0]    order_q  [MP];
	logic [1:0]        err_q, err_d;
	logic [IW-1:0]     eidx_q, eidx_d;

	// Output register.
	logic              ov_q, ov_d;
	logic [1:0]        kind_q, kind_d;
	logic [IW-1:0]     idx_q, idx_d, first_q, first_d, last_q, last_d;
	logic              used_q, used_d, fin_q, fin_d;
	logic [1:0]        stat_q, stat_d;
	logic              can_load;

	assign can_load = !ov_q || !out_stall;

	// Input accept and load decode.
	logic accept;
	logic [MR-1:0] load_r;
	logic [MP-1:0] load_p;
	logic rw_ok, dep_ok;
	pdts_pkg::cell_ctrl_t ctrl;

	assign in_stall = (state_q != pdts_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign rw_ok    = (int'(pass_index) < int'(np)) && (int'(other_index) < int'(nr));
	assign dep_ok   = (int'(pass_index) < int'(np)) && (int'(other_index) < int'(np))
	                  && (pass_index != other_index);

	always_comb begin
		for (int j = 0; j < MR; j++) load_r[j] = (int'(other_index) == j);
		for (int j = 0; j < MP; j++) load_p[j] = (int'(other_index) == j);
	end

	// Cell chain.
	logic [MR-1:0]  rd_rows [MP];
	logic [MR-1:0]  wr_rows [MP];
	logic [MP-1:0]  done_v, pick_v, touch_v;
	logic [MP:0]    found_v;
	logic [PIW-1:0] pos_v [MP];
	logic [MR-1:0]  bcast_r, lt_r;
	logic [MP-1:0]  bcast_w, lt_w;

	assign found_v[0] = 1'b0;

	for (genvar i = 0; i < MP; i++) begin : g_cell
		pdts_cell #(
			.MAX_PASSES    (MP),
			.MAX_RESOURCES (MR),
			.CELL_ID       (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.load_pass (pass_index),
			.load_r    (load_r),
			.load_p    (load_p),
			.pmask     (pmask),
			.bcast_r   (bcast_r),
			.bcast_w   (bcast_w),
			.emitted   (done_v),
			.in_range  (pmask[i]),
			.found_in  (found_v[i]),
			.cur_pos   (cnt_q[PIW-1:0]),
			.lt_r      (lt_r),
			.lt_w      (lt_w[i]),
			.rd_row    (rd_rows[i]),
			.wr_row    (wr_rows[i]),
			.done      (done_v[i]),
			.found_out (found_v[i+1]),
			.pick      (pick_v[i]),
			.touch     (touch_v[i]),
			.pos       (pos_v[i])
		);
	end

	// Row selected by the counter during the writer scan.
	logic [MR-1:0] wrow, rrow, conf, miss;
	logic [IW-1:0] conf_idx, miss_idx;
	logic [PIW-1:0] pick_idx, cur_writer;
	logic [MR-1:0]  cnt_r_oh;
	logic [MP-1:0]  posmask;
	logic [IW-1:0]  pm_first, pm_last;

	assign wrow       = wr_rows[cnt_q[PIW-1:0]] & rmask;
	assign rrow       = rd_rows[cnt_q[PIW-1:0]] & rmask;
	assign conf       = wrow & hw_q;
	assign miss       = rmask & ~ext_vec & ~hw_q & hr_q;
	assign cur_writer = writer_q[cnt_q[RIW-1:0]];

	always_comb begin
		conf_idx = '0;
		miss_idx = '0;
		for (int j = MR - 1; j >= 0; j--) begin
			if (conf[j]) conf_idx = IW'(j);
			if (miss[j]) miss_idx = IW'(j);
		end
		pick_idx = '0;
		for (int i = 0; i < MP; i++) begin
			if (pick_v[i]) pick_idx = pick_idx | PIW'(i);
		end
		for (int j = 0; j < MR; j++) cnt_r_oh[j] = (int'(cnt_q) == j);
		// Positions touched by the current resource, then their lowest and highest.
		posmask = '0;
		for (int i = 0; i < MP; i++) begin
			for (int j = 0; j < MP; j++) begin
				if (touch_v[i] && (int'(pos_v[i]) == j)) posmask[j] = 1'b1;
			end
		end
		pm_first = '0;
		pm_last  = '0;
		for (int j = MP - 1; j >= 0; j--) begin
			if (posmask[j]) pm_first = IW'(j);
		end
		for (int j = 0; j < MP; j++) begin
			if (posmask[j]) pm_last = IW'(j);
		end
	end

	always_comb begin
		bcast_r = '0;
		bcast_w = '0;
		lt_r    = '0;
		lt_w    = '0;
		if (state_q == pdts_pkg::S_PRED) begin
			bcast_r = cnt_r_oh & hw_q & rmask;
			for (int i = 0; i < MP; i++) bcast_w[i] = (int'(cur_writer) == i);
		end
		if (state_q == pdts_pkg::S_EMIT_LIFE) begin
			lt_r = cnt_r_oh & rmask;
			for (int i = 0; i < MP; i++) begin
				lt_w[i] = ((hw_q & cnt_r_oh) != '0) && (int'(cur_writer) == i);
			end
		end
	end

	// Next state and outputs.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		hw_d    = hw_q;
		hr_d    = hr_q;
		err_d   = err_q;
		eidx_d  = eidx_q;
		ctrl    = '0;
		ov_d    = ov_q && out_stall;
		kind_d  = kind_q;
		idx_d   = idx_q;
		first_d = first_q;
		last_d  = last_q;
		used_d  = used_q;
		stat_d  = stat_q;
		fin_d   = fin_q;

		case (state_q)
			pdts_pkg::S_IDLE: begin
				if (accept) begin
					case (mode)
						pdts_pkg::MODE_READ:    ctrl.ld_rd  = rw_ok;
						pdts_pkg::MODE_WRITE:   ctrl.ld_wr  = rw_ok;
						pdts_pkg::MODE_DEP:     ctrl.ld_dep = dep_ok;
						pdts_pkg::MODE_CLEAR:   ctrl.clr    = 1'b1;
						pdts_pkg::MODE_COMPILE: begin
							state_d = pdts_pkg::S_SCAN_W;
							cnt_d   = '0;
							hw_d    = '0;
							hr_d    = '0;
						end
						default: ;
					endcase
				end
			end
			pdts_pkg::S_SCAN_W: begin
				if (cnt_q < np) begin
					if (conf != '0) begin
						err_d   = pdts_pkg::ST_MULTI_WR;
						eidx_d  = conf_idx;
						state_d = pdts_pkg::S_EMIT_STAT;
					end else begin
						hw_d  = hw_q | wrow;
						hr_d  = hr_q | rrow;
						cnt_d = cnt_q + 1'b1;
					end
				end else begin
					state_d = pdts_pkg::S_CHK_RD;
				end
			end
			pdts_pkg::S_CHK_RD: begin
				if (miss != '0) begin
					err_d   = pdts_pkg::ST_NO_WR;
					eidx_d  = miss_idx;
					state_d = pdts_pkg::S_EMIT_STAT;
				end else begin
					ctrl.pred_init = 1'b1;
					cnt_d   = '0;
					state_d = pdts_pkg::S_PRED;
				end
			end
			pdts_pkg::S_PRED: begin
				if (cnt_q < nr) begin
					ctrl.pred_add = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end else begin
					ctrl.sort_init = 1'b1;
					cnt_d   = '0;
					state_d = pdts_pkg::S_SORT;
				end
			end
			pdts_pkg::S_SORT: begin
				if (cnt_q < np) begin
					if (found_v[MP]) begin
						ctrl.sort_step = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end else begin
						err_d   = pdts_pkg::ST_CYCLE;
						eidx_d  = '0;
						state_d = pdts_pkg::S_EMIT_STAT;
					end
				end else begin
					cnt_d   = '0;
					state_d = pdts_pkg::S_EMIT_ORD;
				end
			end
			pdts_pkg::S_EMIT_ORD: begin
				if (cnt_q < np) begin
					if (can_load) begin
						ov_d    = 1'b1;
						kind_d  = pdts_pkg::KIND_ORDER;
						idx_d   = IW'(order_q[cnt_q[PIW-1:0]]);
						first_d = '0;
						last_d  = '0;
						used_d  = 1'b0;
						stat_d  = pdts_pkg::ST_OK;
						fin_d   = 1'b0;
						cnt_d   = cnt_q + 1'b1;
					end
				end else begin
					cnt_d   = '0;
					state_d = pdts_pkg::S_EMIT_LIFE;
				end
			end
			pdts_pkg::S_EMIT_LIFE: begin
				if (cnt_q < nr) begin
					if (can_load) begin
						ov_d    = 1'b1;
						kind_d  = pdts_pkg::KIND_LIFE;
						idx_d   = IW'(cnt_q);
						first_d = pm_first;
						last_d  = pm_last;
						used_d  = (posmask != '0);
						stat_d  = pdts_pkg::ST_OK;
						fin_d   = 1'b0;
						cnt_d   = cnt_q + 1'b1;
					end
				end else begin
					err_d   = pdts_pkg::ST_OK;
					eidx_d  = '0;
					state_d = pdts_pkg::S_EMIT_STAT;
				end
			end
			pdts_pkg::S_EMIT_STAT: begin
				if (can_load) begin
					ov_d    = 1'b1;
					kind_d  = pdts_pkg::KIND_STATUS;
					idx_d   = eidx_q;
					first_d = '0;
					last_d  = '0;
					used_d  = 1'b0;
					stat_d  = err_q;
					fin_d   = 1'b1;
					state_d = pdts_pkg::S_IDLE;
				end
			end
			default: state_d = pdts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdts_pkg::S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

	// Payload and scratch registers.
	always_ff @(posedge clk) begin
		hw_q    <= hw_d;
		hr_q    <= hr_d;
		err_q   <= err_d;
		eidx_q  <= eidx_d;
		kind_q  <= kind_d;
		idx_q   <= idx_d;
		first_q <= first_d;
		last_q  <= last_d;
		used_q  <= used_d;
		stat_q  <= stat_d;
		fin_q   <= fin_d;
		// The scan records each new writer; a conflict aborts the compile, so no overwrite matters.
		if (state_q == pdts_pkg::S_SCAN_W && cnt_q < np && conf == '0) begin
			for (int j = 0; j < MR; j++) begin
				if (wrow[j]) writer_q[j] <= cnt_q[PIW-1:0];
			end
		end
		if (ctrl.sort_step) order_q[cnt_q[PIW-1:0]] <= pick_idx;
	end

	assign out_valid = ov_q;
	assign kind      = kind_q;
	assign index     = idx_q;
	assign first_pos = first_q;
	assign last_pos  = last_q;
	assign used      = used_q;
	assign status    = stat_q;
	assign final_res = fin_q;

endmodule
